@@ hdl/dfmod_pkg.sv @@
// ----------------------------------------------------------------------------
// dfmod_pkg: shared types for the floating-point remainder block
// Sequencer state type, imported by the datapath and the top.
// ----------------------------------------------------------------------------
package dfmod_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM_X,
		ST_NORM_Y,
		ST_LOOP,
		ST_LAST,
		ST_NORM_R,
		ST_PACK,
		ST_DONE
	} state_t;

endpackage

@@ hdl/dfmod_stream_if.sv @@
// ----------------------------------------------------------------------------
// dfmod_stream_if: valid/ready channel
// Carries one payload of parameterized width between a source and a sink.
// ----------------------------------------------------------------------------
interface dfmod_stream_if #(
	parameter int W = 64
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/dfmod_core.sv @@
// ----------------------------------------------------------------------------
// dfmod_core: iterative remainder engine
// One shared subtract/compare and one-bit shifts driven by a small sequencer, plus a wide subnormal shift.
// ----------------------------------------------------------------------------
module dfmod_core import dfmod_pkg::*; #(
	parameter int FRAC_BITS = 52,
	parameter int EXP_BITS  = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [FRAC_BITS+EXP_BITS:0]   x_in,
	input  logic [FRAC_BITS+EXP_BITS:0]   y_in,
	output logic                          done,
	input  logic                          take,
	output logic [FRAC_BITS+EXP_BITS:0]   res,
	output logic                          inv
);
	localparam int FW = 1 + EXP_BITS + FRAC_BITS;
	localparam int MW = FRAC_BITS + 2;   // significand plus one headroom bit
	localparam int EW = EXP_BITS + 2;    // signed exponent width
	localparam logic [EXP_BITS-1:0] EXP_ALL = '1;

	state_t state_q, state_d;
	logic [MW-1:0] mx_q, my_q;
	logic signed [EW-1:0] ex_q, ey_q;
	logic sign_q;
	logic [FW-1:0] res_q;
	logic inv_q;

	logic [FW-2:0] xm, ym;
	logic [EXP_BITS-1:0] xe, ye;
	logic [MW:0] diff;
	logic ge;
	logic special;

	assign xm = x_in[FW-2:0];
	assign ym = y_in[FW-2:0];
	assign xe = xm[FW-2:FRAC_BITS];
	assign ye = ym[FW-2:FRAC_BITS];

	// Special operands and |x| <= |y| resolve at the start without iterating.
	assign special = (ym == '0) || (ye == EXP_ALL && ym[FRAC_BITS-1:0] != '0)
		|| xe == EXP_ALL || xm <= ym;

	// Shared subtractor: mx - my, with borrow telling the compare.
	assign diff = {1'b0, mx_q} - {1'b0, my_q};
	assign ge = ~diff[MW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = special ? ST_DONE : ST_NORM_X;
			ST_NORM_X: if (mx_q[FRAC_BITS]) state_d = ST_NORM_Y;
			ST_NORM_Y: if (my_q[FRAC_BITS]) state_d = ST_LOOP;
			ST_LOOP: begin
				if (ge && diff[MW-1:0] == '0) state_d = ST_DONE;
				else if (ex_q <= ey_q) state_d = ST_LAST;
			end
			ST_LAST:   state_d = (ge && diff[MW-1:0] == '0) ? ST_DONE : ST_NORM_R;
			ST_NORM_R: if (mx_q[FRAC_BITS]) state_d = ST_PACK;
			ST_PACK:   state_d = ST_DONE;
			ST_DONE:   if (take) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				sign_q <= x_in[FW-1];
				mx_q   <= {2'b00, xm[FRAC_BITS-1:0]} | (xe != '0 ? MW'(1) << FRAC_BITS : '0);
				my_q   <= {2'b00, ym[FRAC_BITS-1:0]} | (ye != '0 ? MW'(1) << FRAC_BITS : '0);
				ex_q   <= (xe == '0) ? EW'(1) : EW'(xe);
				ey_q   <= (ye == '0) ? EW'(1) : EW'(ye);
				inv_q  <= 1'b0;
				if (ym == '0 || (ye == EXP_ALL && ym[FRAC_BITS-1:0] != '0) || xe == EXP_ALL) begin
					inv_q <= 1'b1;
					res_q <= FW'({EXP_ALL, 1'b1}) << (FRAC_BITS - 1);
				end else if (xm < ym) begin
					res_q <= x_in;
				end else begin
					res_q <= {x_in[FW-1], {(FW-1){1'b0}}};
				end
			end
			ST_NORM_X: if (!mx_q[FRAC_BITS]) begin
				mx_q <= mx_q << 1;
				ex_q <= ex_q - EW'(1);
			end
			ST_NORM_Y: if (!my_q[FRAC_BITS]) begin
				my_q <= my_q << 1;
				ey_q <= ey_q - EW'(1);
			end
			ST_LOOP: if (ex_q > ey_q) begin
				mx_q <= (ge ? diff[MW-1:0] : mx_q) << 1;
				ex_q <= ex_q - EW'(1);
			end
			ST_LAST: if (ge) mx_q <= diff[MW-1:0];
			ST_NORM_R: if (!mx_q[FRAC_BITS]) begin
				mx_q <= mx_q << 1;
				ex_q <= ex_q - EW'(1);
			end
			ST_PACK: begin
				if (ex_q > 0) begin
					res_q <= {sign_q, ex_q[EXP_BITS-1:0], mx_q[FRAC_BITS-1:0]};
				end else begin
					// Subnormal result: a single wide shift, bounded by the format.
					res_q <= {sign_q, (FW-1)'(mx_q >> (EW'(1) - ex_q))};
				end
			end
			default: ;
		endcase
	end

	assign done = (state_q == ST_DONE);
	assign res  = res_q;
	assign inv  = inv_q;
endmodule

@@ hdl/double_fmod_remainder_top.sv @@
// Result time grows with the exponent difference and the normalization shifts;
// special operands and |x| <= |y| give the result in the cycle after the transfer.
// Throughput: one item at a time; in.ready is high only while idle.
// The shift-subtract loop in dfmod_core takes one exponent step per cycle.
// Reset arst_n is asynchronous; it returns the sequencer to idle, no result pending.
// ----------------------------------------------------------------------------
// double_fmod_remainder_top: binary64 truncated remainder
// Wraps the iterative core with the input and output channels.
// ----------------------------------------------------------------------------
module double_fmod_remainder_top import dfmod_pkg::*; #(
	parameter int FRAC_BITS = 52,
	parameter int EXP_BITS  = 11
) (
	input logic clk,
	input logic arst_n,
	dfmod_stream_if.sink   in,
	dfmod_stream_if.source out
);
	localparam int FW = 1 + EXP_BITS + FRAC_BITS;
	logic done, inv;
	logic [FW-1:0] res;
	logic busy_q;

	dfmod_core #(.FRAC_BITS(FRAC_BITS), .EXP_BITS(EXP_BITS)) u_core (
		.clk(clk), .arst_n(arst_n),
		.start(in.valid & in.ready),
		.x_in(in.data[FW-1:0]),
		.y_in(in.data[64+FW-1:64]),
		.done(done),
		.take(out.ready),
		.res(res),
		.inv(inv)
	);

	assign in.ready  = ~done & ~busy_q;
	assign out.valid = done;
	assign out.data  = {inv, 64'(res)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else if (in.valid & in.ready) busy_q <= 1'b1;
		else if (done) busy_q <= 1'b0;
	end
endmodule

@@ hdl/dfmod_checker.sv @@
// ----------------------------------------------------------------------------
// dfmod_checker: port-level checks for the remainder block
// Watches the handshakes and the canonical NaN encoding.
// ----------------------------------------------------------------------------
module dfmod_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [64:0] out_data
);
	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
	a_nan_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[64] |-> out_data[63:0] == 64'h7FF8000000000000)
		else $error("invalid without canonical NaN");
endmodule

bind double_fmod_remainder_top dfmod_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready),
	.out_data(out.data)
);
